// ===== src/steering_pd_with_gear_select_top_macros.svh =====
// Assertion macros used by the checker file
`ifndef STEERING_PD_WITH_GEAR_SELECT_TOP_MACROS_SVH
`define STEERING_PD_WITH_GEAR_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spg check failed");

// Next-cycle implication, disabled during reset
`define SPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spg check failed");

`endif

// ===== src/spg_pkg.sv =====
package spg_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FRAME_END,
        ST_P_MUL,
        ST_D_MUL,
        ST_D_ADD,
        ST_ROUND,
        ST_DONE
    } spg_state_t;

    // Accumulator operations of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_X16,
        ACC_ADD
    } spg_acc_op_t;

    typedef struct packed {
        logic        mul_en;
        spg_acc_op_t acc_op;
    } spg_mac_ctrl_t;

    // Datapath widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 52;
    localparam int DIV_N_W = 36;
    localparam int DIV_D_W = 16;
    localparam int RATE_W  = 32;

    // Microseconds per second
    localparam int RATE_SCALE = 1000000;

    // Register map
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_P_GAIN    = 2'd0;
    localparam logic [1:0] REG_D_GAIN    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_ENGINE    = 2'd3;

    // Gear codes
    localparam logic [1:0] GEAR_LOST = 2'd0;
    localparam logic [1:0] GEAR_SLOW = 2'd1;
    localparam logic [1:0] GEAR_FULL = 2'd2;

endpackage

// ===== src/spg_in_if.sv =====
interface spg_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic               line_ok;
    logic signed [15:0] track_offset;
    logic        [15:0] period_us;
    logic signed [15:0] pot_offset;
    logic               drive_switch;

    modport source (
        output valid, cmd, line_ok, track_offset, period_us, pot_offset, drive_switch,
        input  ready
    );

    modport sink (
        input  valid, cmd, line_ok, track_offset, period_us, pot_offset, drive_switch,
        output ready
    );
endinterface

// ===== src/spg_out_if.sv =====
interface spg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] servo_command;
    logic signed [15:0] motor_duty;
    logic               bridge_enable;
    logic        [1:0]  gear_now;
    logic               servo_updated;

    modport source (
        output valid, servo_command, motor_duty, bridge_enable, gear_now, servo_updated,
        input  ready
    );

    modport sink (
        input  valid, servo_command, motor_duty, bridge_enable, gear_now, servo_updated,
        output ready
    );
endinterface

// ===== src/spg_div.sv =====
// Restoring divider, one quotient bit per cycle
module spg_div
    import spg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   trial_sub;
    logic               fits;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        quo_next  = {quo_reg[DIV_N_W-2:0], fits};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/spg_mac.sv =====
// Shared multiplier with registered product and accumulator
module spg_mac
    import spg_pkg::*;
(
    input  logic                      clk,
    input  spg_mac_ctrl_t             ctrl,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    input  logic signed [ACC_W-1:0]   load_val,
    output logic signed [PROD_W-1:0]  prod,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    assign prod_next = a * b;

    // Accumulator update
    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_LOAD:    acc_next = load_val;
            ACC_ADD_X16: acc_next = acc_reg + (ACC_W'(prod_reg) <<< 4);
            ACC_ADD:     acc_next = acc_reg + ACC_W'(prod_reg);
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== src/steering_pd_with_gear_select_top.sv =====
// Line-following steering PD controller with speed gear selection.
// Channel item_ch carries one beat per camera frame (cmd 0) or servo
// tick (cmd 1); channel result_ch returns exactly one beat per item
// beat: the steering command, the motor duty, the bridge enable, the gear
// and whether this beat recomputed the servo command.
// The APB port sets p_gain, d_gain, gear_threshold and engine_command at
// byte addresses 0, 4, 8 and 12; write it only while the block is idle.
// One item is worked on at a time; item_ch.ready is high only when idle.
// A valid frame forms the rate from one multiply of the error difference
// by 10^6 and a 36-step radix-2 divider by the frame period. A servo tick
// makes two passes through the shared multiplier, then accumulates, clamps
// and rounds. An invalid frame skips the multiply and the divider. The next
// item can be taken in the cycle after the result is loaded.
// The result sits in an output register; the next item is accepted while
// it waits, and that item stalls in its last step until result_ch takes it.
// Reset clears the error, rate, gear and steering state to zero and loads
// the register defaults; no output beat is pending after reset.
module steering_pd_with_gear_select_top
    import spg_pkg::*;
#(
    parameter int COMMAND_FRAC_BITS = 14
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    spg_in_if.sink                item_ch,
    spg_out_if.source             result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SUM_SHIFT = 32 - COMMAND_FRAC_BITS;
    localparam longint FULL  = longint'(1) << COMMAND_FRAC_BITS;
    localparam logic [15:0] DUTY_GEAR0 = 16'((4 * FULL + 5) / 10);
    localparam logic [15:0] DUTY_GEAR1 = 16'(FULL / 2);
    localparam int DRV_W = 21;
    localparam logic [DRV_W-1:0] DRV_FULL = DRV_W'(FULL);
    localparam int CLAMP_W = 34;
    localparam logic signed [ACC_W-1:0]   ACC_ONE   = ACC_W'(longint'(1) << 32);
    localparam logic signed [ACC_W-1:0]   ACC_MONE  = -ACC_ONE;
    localparam logic signed [CLAMP_W-1:0] CLP_ONE   = CLAMP_W'(longint'(1) << 32);
    localparam logic signed [CLAMP_W:0]   RND_HALF  = (CLAMP_W+1)'(longint'(1) << (SUM_SHIFT - 1));
    localparam logic [DIV_N_W-1:0] Q_POS_MAX = DIV_N_W'(longint'(32'h7FFF_FFFF));
    localparam logic [DIV_N_W-1:0] Q_NEG_MAX = DIV_N_W'(longint'(1) << 31);

    // Configuration registers
    logic [15:0]        p_gain_reg;
    logic [15:0]        d_gain_reg;
    logic [14:0]        threshold_reg;
    logic signed [15:0] engine_reg;

    // Controller state
    logic signed [15:0]       last_error_reg;
    logic signed [RATE_W-1:0] rate_reg, rate_next;
    logic [1:0]               gear_reg, gear_next;
    logic [15:0]              steer_reg, steer_next;

    // Captured item
    logic                     cmd_reg;
    logic                     line_ok_reg;
    logic signed [15:0]       pos_reg;
    logic [15:0]              period_reg;
    logic signed [15:0]       pot_reg;
    logic                     drive_reg;
    logic signed [MUL_A_W-1:0] diff_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [15:0]       out_servo_reg;
    logic signed [15:0]       out_duty_reg;
    logic                     out_enable_reg;
    logic [1:0]               out_gear_reg;
    logic                     out_updated_reg;

    spg_state_t state_reg, state_next;

    // Sequencer outputs
    logic                      accept;
    logic                      div_start;
    logic                      frame_end;
    logic                      steer_en;
    logic                      out_load;
    spg_mac_ctrl_t             mac_ctrl;
    logic signed [MUL_A_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;

    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   pot_term;
    logic                      div_done;
    logic [DIV_N_W-1:0]        quotient;
    logic [PROD_W-1:0]         prod_mag;
    logic [DIV_D_W-1:0]        divisor;

    logic                      cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg    <= 16'd13631;
            d_gain_reg    <= 16'd15938;
            threshold_reg <= 15'd1280;
            engine_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_P_GAIN:    p_gain_reg    <= pwdata[15:0];
                REG_D_GAIN:    d_gain_reg    <= pwdata[15:0];
                REG_THRESHOLD: threshold_reg <= pwdata[14:0];
                REG_ENGINE:    engine_reg    <= pwdata[15:0];
                default:       p_gain_reg    <= p_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_P_GAIN:    prdata = {16'd0, p_gain_reg};
            REG_D_GAIN:    prdata = {16'd0, d_gain_reg};
            REG_THRESHOLD: prdata = {17'd0, threshold_reg};
            REG_ENGINE:    prdata = {16'd0, engine_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_ch.valid)
                begin
                    if (item_ch.cmd)
                        state_next = ST_P_MUL;
                    else if (item_ch.line_ok)
                        state_next = ST_DIFF_MUL;
                    else
                        state_next = ST_FRAME_END;
                end
            end
            ST_DIFF_MUL:  state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ST_FRAME_END;
            end
            ST_FRAME_END: state_next = ST_DONE;
            ST_P_MUL:     state_next = ST_D_MUL;
            ST_D_MUL:     state_next = ST_D_ADD;
            ST_D_ADD:     state_next = ST_ROUND;
            ST_ROUND:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || result_ch.ready)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and multiplier operand select
    always_comb
    begin
        accept          = 1'b0;
        div_start       = 1'b0;
        frame_end       = 1'b0;
        steer_en        = 1'b0;
        out_load        = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = ACC_HOLD;
        mac_a           = diff_reg;
        mac_b           = MUL_B_W'(RATE_SCALE);
        case (state_reg)
            ST_IDLE:      accept = item_ch.valid;
            ST_DIFF_MUL:  mac_ctrl.mul_en = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_FRAME_END: frame_end = 1'b1;
            ST_P_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_LOAD;
                mac_a           = {1'b0, p_gain_reg};
                mac_b           = MUL_B_W'(last_error_reg);
            end
            ST_D_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_ADD_X16;
                mac_a           = {1'b0, d_gain_reg};
                mac_b           = MUL_B_W'(rate_reg);
            end
            ST_D_ADD:     mac_ctrl.acc_op = ACC_ADD;
            ST_ROUND:     steer_en = 1'b1;
            ST_DONE:      out_load = !out_valid_reg || result_ch.ready;
            default:      accept = 1'b0;
        endcase
    end

    assign item_ch.ready = (state_reg == ST_IDLE);

    // Capture the item; the error difference is formed here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= item_ch.cmd;
            line_ok_reg <= item_ch.line_ok;
            pos_reg     <= item_ch.track_offset;
            period_reg  <= item_ch.period_us;
            pot_reg     <= item_ch.pot_offset;
            drive_reg   <= item_ch.drive_switch;
            diff_reg    <= MUL_A_W'(item_ch.track_offset) - MUL_A_W'(last_error_reg);
        end
    end

    // ---------------- shared multiply-accumulate ----------------
    assign pot_term = ACC_W'(pot_reg) <<< SUM_SHIFT;

    spg_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .a        (mac_a),
        .b        (mac_b),
        .load_val (pot_term),
        .prod     (prod),
        .acc      (acc)
    );

    // ---------------- rate divider ----------------
    assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign divisor  = (period_reg == '0) ? DIV_D_W'(1) : period_reg;

    spg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DIV_N_W-1:0]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Frame end: saturate the rate and choose the gear; a lost line clears the rate and selects the lost gear
    logic signed [16:0] pos_ext;
    logic [16:0]        pos_mag;

    always_comb
    begin
        pos_ext = 17'(pos_reg);
        pos_mag = pos_ext[16] ? 17'(-pos_ext) : 17'(pos_ext);
        if (!line_ok_reg)
        begin
            rate_next = '0;
            gear_next = GEAR_LOST;
        end
        else
        begin
            if (diff_reg[MUL_A_W-1])
                rate_next = (quotient > Q_NEG_MAX) ? RATE_W'(Q_NEG_MAX)
                                                   : -RATE_W'(quotient);
            else
                rate_next = (quotient > Q_POS_MAX) ? RATE_W'(Q_POS_MAX)
                                                   : RATE_W'(quotient);
            gear_next = (pos_mag > 17'(threshold_reg)) ? GEAR_SLOW : GEAR_FULL;
        end
    end

    // Servo: clamp to plus or minus one, round to nearest, ties upward
    logic signed [CLAMP_W-1:0] clamped;
    logic signed [CLAMP_W:0]   rounded;

    always_comb
    begin
        if (acc > ACC_ONE)
            clamped = CLP_ONE;
        else if (acc < ACC_MONE)
            clamped = -CLP_ONE;
        else
            clamped = acc[CLAMP_W-1:0];
        rounded    = ((CLAMP_W+1)'(clamped) + RND_HALF) >>> SUM_SHIFT;
        steer_next = rounded[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            rate_reg       <= '0;
            gear_reg       <= GEAR_LOST;
            steer_reg      <= '0;
        end
        else
        begin
            if (frame_end)
            begin
                rate_reg <= rate_next;
                gear_reg <= gear_next;
                if (line_ok_reg)
                    last_error_reg <= pos_reg;
            end
            if (steer_en)
                steer_reg <= steer_next;
        end
    end

    // ---------------- motor drive ----------------
    logic signed [16:0] eng_ext;
    logic [16:0]        eng_mag;
    logic [DRV_W-1:0]   eng_mag10;
    logic               drive_on;
    logic [15:0]        duty;

    always_comb
    begin
        eng_ext   = 17'(engine_reg);
        eng_mag   = eng_ext[16] ? 17'(-eng_ext) : 17'(eng_ext);
        eng_mag10 = DRV_W'({eng_mag, 3'b000}) + DRV_W'({eng_mag, 1'b0});
        drive_on  = drive_reg && (eng_mag10 >= DRV_FULL);
        case (gear_reg)
            GEAR_SLOW: duty = DUTY_GEAR1;
            GEAR_FULL: duty = engine_reg;
            default:   duty = DUTY_GEAR0;
        endcase
        if (!drive_on)
            duty = '0;
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_servo_reg   <= steer_reg;
            out_duty_reg    <= duty;
            out_enable_reg  <= drive_on;
            out_gear_reg    <= gear_reg;
            out_updated_reg <= cmd_reg;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.servo_command = out_servo_reg;
    assign result_ch.motor_duty    = out_duty_reg;
    assign result_ch.bridge_enable = out_enable_reg;
    assign result_ch.gear_now      = out_gear_reg;
    assign result_ch.servo_updated = out_updated_reg;

endmodule

// ===== src/spg_checker.sv =====
`include "steering_pd_with_gear_select_top_macros.svh"

// Port-level checks on the controller
module spg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        bridge_enable,
    input logic [15:0] motor_duty
);

    // A stalled output beat stays offered
    `SPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // One item at a time: ready drops after an input beat
    `SPG_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // Bridge off means zero duty
    `SPG_ASSERT_IMP(a_bridge_off, clk, rst_n, out_valid && !bridge_enable, motor_duty == 16'd0)

endmodule

bind steering_pd_with_gear_select_top spg_checker u_spg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item_ch.valid),
    .in_ready      (item_ch.ready),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .bridge_enable (result_ch.bridge_enable),
    .motor_duty    (result_ch.motor_duty)
);

// ===== test/tb_steering_pd_with_gear_select_top.sv =====
module tb_steering_pd_with_gear_select_top;
    import spg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  COMMAND_FRAC_BITS = 14;
    localparam int  SUM_SHIFT         = 32 - COMMAND_FRAC_BITS;
    localparam int  CYCLE_LIMIT       = 600000;
    localparam int  SETTLE_CYCLES     = 60;
    localparam int  LONG_HOLD         = 400;
    localparam int  N_PHASES          = 10;
    localparam int  ITEMS_PER_PHASE   = 93;
    localparam bit  CMD_FRAME         = 1'b0;
    localparam bit  CMD_TICK          = 1'b1;
    localparam longint RATE_MAX       = 64'sd2147483647;
    localparam longint RATE_MIN       = -64'sd2147483648;

    typedef struct packed {
        logic               cmd;
        logic               line_ok;
        logic signed [15:0] track_offset;
        logic        [15:0] period_us;
        logic signed [15:0] pot_offset;
        logic               drive_switch;
    } ctrl_item_t;

    typedef struct packed {
        logic signed [15:0] servo_command;
        logic signed [15:0] motor_duty;
        logic               bridge_enable;
        logic        [1:0]  gear_now;
        logic               servo_updated;
    } steer_result_t;

    // Controller model: register copy, PD state, queue of expected beats
    class steer_scoreboard;
        bit        [15:0] p_gain;
        bit        [15:0] d_gain;
        bit        [14:0] gear_thr;
        bit signed [15:0] engine_cmd;
        bit signed [15:0] err_q;
        bit signed [31:0] rate_q;
        bit        [1:0]  gear_q;
        bit signed [15:0] steer_q;
        steer_result_t    expected_q[$];
        int               errors;
        int               n_frames;
        int               n_lost;
        int               n_ticks;

        function new();
            p_gain     = 16'd13631;
            d_gain     = 16'd15938;
            gear_thr   = 15'd1280;
            engine_cmd = '0;
            err_q      = '0;
            rate_q     = '0;
            gear_q     = GEAR_LOST;
            steer_q    = '0;
            errors     = 0;
            n_frames   = 0;
            n_lost     = 0;
            n_ticks    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_P_GAIN:    p_gain     = value[15:0];
                REG_D_GAIN:    d_gain     = value[15:0];
                REG_THRESHOLD: gear_thr   = value[14:0];
                REG_ENGINE:    engine_cmd = value[15:0];
                default:       ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the controller by one accepted beat and queue its result
        function void note_input(ctrl_item_t it);
            longint        diff;
            longint        r;
            longint        per;
            longint        s;
            longint        one;
            int            mag;
            int            eng_mag;
            int            full;
            steer_result_t res;
            if (it.cmd == CMD_TICK)
            begin
                n_ticks++;
                one = longint'(1) << 32;
                s = longint'(p_gain) * longint'(err_q) * 16
                  + longint'(d_gain) * longint'(rate_q)
                  + longint'(it.pot_offset) * (longint'(1) << SUM_SHIFT);
                if (s > one)
                    s = one;
                if (s < -one)
                    s = -one;
                // round to nearest, ties toward plus infinity
                steer_q = 16'((s + (longint'(1) << (SUM_SHIFT - 1))) >>> SUM_SHIFT);
            end
            else if (it.line_ok)
            begin
                n_frames++;
                diff = longint'(it.track_offset) - longint'(err_q);
                per  = (it.period_us == 0) ? 1 : longint'(it.period_us);
                r    = diff * RATE_SCALE / per;
                if (r > RATE_MAX)
                    r = RATE_MAX;
                if (r < RATE_MIN)
                    r = RATE_MIN;
                err_q  = it.track_offset;
                rate_q = 32'(r);
                mag = (it.track_offset < 0) ? -int'(it.track_offset)
                                            : int'(it.track_offset);
                gear_q = (mag > int'(gear_thr)) ? GEAR_SLOW : GEAR_FULL;
            end
            else
            begin
                // line lost: rate cleared, error kept
                n_frames++;
                n_lost++;
                rate_q = '0;
                gear_q = GEAR_LOST;
            end

            // motor drive from switch, engine command and gear
            full    = 1 << COMMAND_FRAC_BITS;
            eng_mag = (engine_cmd < 0) ? -int'(engine_cmd) : int'(engine_cmd);
            res.motor_duty    = '0;
            res.bridge_enable = 1'b0;
            if (it.drive_switch && eng_mag * 10 >= full)
            begin
                res.bridge_enable = 1'b1;
                case (gear_q)
                    GEAR_SLOW: res.motor_duty = 16'(full / 2);
                    GEAR_FULL: res.motor_duty = engine_cmd;
                    default:   res.motor_duty = 16'((4 * full + 5) / 10);
                endcase
            end
            res.servo_command = steer_q;
            res.gear_now      = gear_q;
            res.servo_updated = it.cmd;
            expected_q.push_back(res);
        endfunction

        function void compare(string name, logic [15:0] exp, logic [15:0] got);
            if (got !== exp)
            begin
                $error("%s: expected %0d, got %0d", name, $signed(exp), $signed(got));
                errors++;
            end
        endfunction

        function void check(steer_result_t got);
            steer_result_t exp;
            if (expected_q.size() == 0)
            begin
                $error("output beat with no input waiting for it");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            compare("servo_command", exp.servo_command, got.servo_command);
            compare("motor_duty", exp.motor_duty, got.motor_duty);
            compare("bridge_enable", 16'(exp.bridge_enable), 16'(got.bridge_enable));
            compare("gear_now", 16'(exp.gear_now), 16'(got.gear_now));
            compare("servo_updated", 16'(exp.servo_updated), 16'(got.servo_updated));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    spg_in_if  item_ch();
    spg_out_if result_ch();

    steer_scoreboard sb;
    int              burst_left;
    int              hold_asks;
    int              n_writes;
    int              cycle_count;

    steering_pd_with_gear_select_top #(
        .COMMAND_FRAC_BITS(COMMAND_FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // APB write: setup beat, then access beat until pready
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        n_writes++;
        @(posedge clk);
    endtask

    task automatic configure(int p, int d, int thr, int eng);
        apb_write(REG_P_GAIN, 32'(p));
        apb_write(REG_D_GAIN, 32'(d));
        apb_write(REG_THRESHOLD, 32'(thr));
        apb_write(REG_ENGINE, 32'(eng));
    endtask

    // Offer one beat and hold it until the block takes it
    task automatic send_item(ctrl_item_t it);
        item_ch.valid        <= 1'b1;
        item_ch.cmd          <= it.cmd;
        item_ch.line_ok      <= it.line_ok;
        item_ch.track_offset <= it.track_offset;
        item_ch.period_us    <= it.period_us;
        item_ch.pot_offset   <= it.pot_offset;
        item_ch.drive_switch <= it.drive_switch;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_input(it);
    endtask

    // Bursts of random length separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait for every queued result, then let the block settle
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic ctrl_item_t mk_item(bit cmd, bit ok, int pos, int per, int pot, bit sw);
        ctrl_item_t it;
        it.cmd          = cmd;
        it.line_ok      = ok;
        it.track_offset = 16'(pos);
        it.period_us    = 16'(per);
        it.pot_offset   = 16'(pot);
        it.drive_switch = sw;
        return it;
    endfunction

    // Frames and ticks in random mix, mostly realistic values, some full-range noise
    function automatic ctrl_item_t random_item();
        ctrl_item_t it;
        int         pick;
        pick = $urandom_range(0, 99);
        it.cmd     = (pick < 48) ? CMD_FRAME : CMD_TICK;
        it.line_ok = (pick >= 40 && pick < 48) ? 1'b0 :
                     (it.cmd == CMD_TICK) ? 1'($urandom_range(0, 1)) : 1'b1;
        if ($urandom_range(0, 2) == 0)
            it.track_offset = 16'($urandom);
        else
            it.track_offset = 16'($urandom_range(0, 6000)) - 16'd3000;
        case ($urandom_range(0, 7))
            0:       it.period_us = 16'd0;
            1:       it.period_us = 16'd1;
            2:       it.period_us = 16'hFFFF;
            3, 4:    it.period_us = 16'($urandom);
            default: it.period_us = 16'($urandom_range(5000, 20000));
        endcase
        it.pot_offset   = 16'($urandom_range(0, 32768)) - 16'd16384;
        it.drive_switch = ($urandom_range(0, 6) != 0);
        return it;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        steer_result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.servo_command = result_ch.servo_command;
            got.motor_duty    = result_ch.motor_duty;
            got.bridge_enable = result_ch.bridge_enable;
            got.gear_now      = result_ch.gear_now;
            got.servo_updated = result_ch.servo_updated;
            sb.check(got);
        end
    end

    // Receiver: stall pattern in random modes, plus long holds on request
    initial
    begin
        int mode;
        int left;
        int hold_done;
        int held;
        mode      = 0;
        left      = 0;
        hold_done = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_asks > hold_done)
            begin
                hold_done++;
                result_ch.ready <= 1'b0;
                held = 1;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 150);
                end
                left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= (left % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("steering_pd_with_gear_select_top test failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        int preset_p[5];
        int preset_d[5];
        int preset_t[5];
        int preset_e[5];
        preset_p = '{13631, 0,     65535, 0,     65535};
        preset_d = '{15938, 0,     65535, 65535, 0};
        preset_t = '{1280,  0,     32767, 1280,  0};
        preset_e = '{16384, 1639, -16384, 1638, -1639};

        sb         = new();
        burst_left = 0;
        hold_asks  = 0;
        n_writes   = 0;

        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.cmd          <= CMD_FRAME;
        item_ch.line_ok      <= 1'b0;
        item_ch.track_offset <= '0;
        item_ch.period_us    <= '0;
        item_ch.pot_offset   <= '0;
        item_ch.drive_switch <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, engine command zero so the drive is off
        send_item(mk_item(CMD_TICK,  1'b0, 0, 0, 0, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b1, 1280, 10000, 0, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b1, 1281, 0, 0, 1'b0));
        wait_idle();

        // directed: smallest engine command that still drives
        apb_write(REG_ENGINE, 32'(1639));
        send_item(mk_item(CMD_FRAME, 1'b1, -1280, 1, 0, 1'b1));
        send_item(mk_item(CMD_TICK,  1'b0, 0, 0, 16384, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b1, 32767, 1, -16384, 1'b1));
        send_item(mk_item(CMD_TICK,  1'b1, -32768, 65535, -16384, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b1, -32768, 1, 0, 1'b1));
        send_item(mk_item(CMD_TICK,  1'b0, 0, 0, 0, 1'b0));
        send_item(mk_item(CMD_FRAME, 1'b0, 12345, 500, 999, 1'b1));
        send_item(mk_item(CMD_TICK,  1'b1, 32767, 0, 100, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b1, -1281, 65535, 0, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b1, 0, 65535, 0, 1'b0));
        send_item(mk_item(CMD_TICK,  1'b0, -1, 1, 16384, 1'b1));
        send_item(mk_item(CMD_FRAME, 1'b0, -1, 0, 0, 1'b0));
        send_item(mk_item(CMD_TICK,  1'b1, 0, 0, -16384, 1'b1));
        wait_idle();

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 5)
                configure(preset_p[ph], preset_d[ph], preset_t[ph], preset_e[ph]);
            else
                configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 32767), $urandom_range(0, 32768) - 16384);
            // output side holds off while input keeps coming
            if (ph == 1)
                hold_asks++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (k > 0)
                    pace();
                send_item(random_item());
            end
            wait_idle();
        end

        $display("covered %0d frames (%0d with the line lost) and %0d servo ticks",
                 sb.n_frames, sb.n_lost, sb.n_ticks);
        $display("under %0d register writes across gain, threshold and engine extremes",
                 n_writes);
        if (sb.errors == 0)
            $display("steering_pd_with_gear_select_top test passed");
        else
            $display("steering_pd_with_gear_select_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/spg_pkg.sv
src/spg_in_if.sv
src/spg_out_if.sv
src/spg_div.sv
src/spg_mac.sv
src/steering_pd_with_gear_select_top.sv
src/spg_checker.sv
test/tb_steering_pd_with_gear_select_top.sv
